>>> hw/rtl/ffde_pkg.sv
// shared constants for the fold fractal distance estimator
`default_nettype none

package ffde_pkg;

	// configuration register
	localparam int FOLD_ITER_W = 5;
	localparam logic [FOLD_ITER_W-1:0] FOLD_ITER_RESET = 5'd8;

	// final rounding: guard bits kept below the fraction while reducing
	localparam int GUARD_BITS = 6;

	// reduced coordinate, absolute value and octahedron sum widths
	localparam int RED_W = 40;
	// clamped octahedron distance, +-2^(32+GUARD_BITS)
	localparam int CLAMP_W = 40;
	localparam int CLAMP_EXP = 32 + GUARD_BITS;

	// 1/sqrt(3) in unsigned fixed point, 24 fraction bits
	localparam int CONST_BITS = 24;
	localparam logic [CONST_BITS-1:0] INV_SQRT3_Q24 = 24'd9686330;

	// the clamped distance is split into two halves for the constant multiply
	localparam int SPLIT_W = 20;
	localparam int HI_W = CLAMP_W - SPLIT_W;
	localparam int PH_W = HI_W + CONST_BITS + 1;
	localparam int PL_W = SPLIT_W + CONST_BITS;
	localparam int PROD_W = 64;
	localparam int RES_W = PROD_W - CONST_BITS - GUARD_BITS;

	// output format
	localparam int DIST_W = 32;
	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> hw/rtl/fold_fractal_distance_estimate_top.sv
// distance estimate to a square-based sierpinski pyramid by repeated folding
`default_nettype none

// Takes one signed fixed point query point per cycle and returns one saturated
// distance estimate per point, in order. Every point runs through four pipeline
// stages per possible iteration (one reflection plane each, the last one also
// scaling by two about (0,1,0)), whether or not the iteration is enabled, then
// seven stages of final reduction, the split constant multiply and saturation,
// and the output register; a new point may enter every cycle while point_stall
// is low. A two-entry output buffer lets one more transaction finish while the
// sink stalls; point_stall rises only once that buffer is full. Coordinates
// are kept exactly as full-width integers, so fold decisions never suffer
// rounding. fold_iterations above MAX_FOLD_ITERATIONS acts as
// MAX_FOLD_ITERATIONS; cfg_ready is always high and the register should only
// be written while no transaction is in flight.
module fold_fractal_distance_estimate_top
	import ffde_pkg::*;
#(
	parameter int MAX_FOLD_ITERATIONS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [FOLD_ITER_W-1:0]        fold_iterations,
	// query point channel
	input  wire logic                          point_valid,
	output logic                               point_stall,
	input  wire logic signed [31:0]            point_x,
	input  wire logic signed [31:0]            point_y,
	input  wire logic signed [31:0]            point_z,
	// distance channel
	output logic                               dist_valid,
	input  wire logic                          dist_stall,
	output logic signed [DIST_W-1:0]           distance,
	output logic                               saturated
);

	// exact coordinate width: 2^k*a + o with |a| <= 2^31, |o| < 2^(k+FRAC_BITS)
	localparam int CW = MAX_FOLD_ITERATIONS + 34;
	localparam int IW = $clog2(MAX_FOLD_ITERATIONS + 1);
	localparam int NS = 4 * MAX_FOLD_ITERATIONS;
	localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam int CSTW = FRAC_BITS + GUARD_BITS + 1;
	localparam logic [CSTW-1:0] ONE_G = CSTW'(1) << (FRAC_BITS + GUARD_BITS);
	localparam logic signed [RED_W+1:0] LIM = (RED_W+2)'(1) << CLAMP_EXP;

	// exact reduction floor(c*2^GUARD_BITS / 2^n)
	function automatic logic signed [RED_W-1:0] reduce_f(
		input logic signed [CW-1:0] c,
		input logic [IW-1:0]        n
	);
		logic signed [CW+GUARD_BITS-1:0] cg;
		logic signed [CW+GUARD_BITS-1:0] sh;
		cg = {c, {GUARD_BITS{1'b0}}};
		sh = cg >>> n;
		return sh[RED_W-1:0];
	endfunction

	logic en;
	logic [FOLD_ITER_W-1:0] fold_iterations_q;
	logic [IW-1:0] iters_c;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_iterations_q <= FOLD_ITER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fold_iterations_q <= fold_iterations;
		end
	end

	// iteration count clamped to the pipeline depth
	assign iters_c = (int'(fold_iterations_q) > MAX_FOLD_ITERATIONS) ?
		IW'(MAX_FOLD_ITERATIONS) : IW'(fold_iterations_q);

	// fold pipeline registers, index k holds the input of fold stage k
	logic                   fold_v_s  [0:NS];
	logic signed [CW-1:0]   fold_x_s  [0:NS];
	logic signed [CW-1:0]   fold_y_s  [0:NS];
	logic signed [CW-1:0]   fold_z_s  [0:NS];
	logic [IW-1:0]          fold_it_s [0:NS];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_v_s[0] <= 1'b0;
		end else if (en) begin
			fold_v_s[0] <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_x_s[0]  <= {{(CW-32){point_x[31]}}, point_x};
			fold_y_s[0]  <= {{(CW-32){point_y[31]}}, point_y};
			fold_z_s[0]  <= {{(CW-32){point_z[31]}}, point_z};
			fold_it_s[0] <= iters_c;
		end
	end

	// one reflection plane per stage, the fourth plane also scales
	for (genvar k = 0; k < NS; k++) begin : g_fold
		localparam int ITER = k / 4;
		localparam int STEP = k % 4;

		logic                 act;
		logic signed [CW:0]   sum;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic signed [CW-1:0] nz;

		always_comb begin
			act = (fold_it_s[k] > IW'(ITER));
			nx = fold_x_s[k];
			ny = fold_y_s[k];
			nz = fold_z_s[k];
			sum = '0;
			case (STEP)
				0: begin
					// x+y<0: reflect with negation
					sum = {fold_x_s[k][CW-1], fold_x_s[k]} + {fold_y_s[k][CW-1], fold_y_s[k]};
					if (act && sum[CW]) begin
						nx = -fold_y_s[k];
						ny = -fold_x_s[k];
					end
				end
				1: begin
					// y<x: swap
					sum = {fold_y_s[k][CW-1], fold_y_s[k]} - {fold_x_s[k][CW-1], fold_x_s[k]};
					if (act && sum[CW]) begin
						nx = fold_y_s[k];
						ny = fold_x_s[k];
					end
				end
				2: begin
					// y+z<0: reflect with negation
					sum = {fold_y_s[k][CW-1], fold_y_s[k]} + {fold_z_s[k][CW-1], fold_z_s[k]};
					if (act && sum[CW]) begin
						ny = -fold_z_s[k];
						nz = -fold_y_s[k];
					end
				end
				default: begin
					// y<z: swap, then scale by two about (0,1,0)
					sum = {fold_y_s[k][CW-1], fold_y_s[k]} - {fold_z_s[k][CW-1], fold_z_s[k]};
					if (act && sum[CW]) begin
						ny = fold_z_s[k];
						nz = fold_y_s[k];
					end
					if (act) begin
						nx = {nx[CW-2:0], 1'b0};
						ny = {ny[CW-2:0], 1'b0} - ONE_C;
						nz = {nz[CW-2:0], 1'b0};
					end
				end
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fold_v_s[k+1] <= 1'b0;
			end else if (en) begin
				fold_v_s[k+1] <= fold_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fold_x_s[k+1]  <= nx;
				fold_y_s[k+1]  <= ny;
				fold_z_s[k+1]  <= nz;
				fold_it_s[k+1] <= fold_it_s[k];
			end
		end
	end

	// tail pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [RED_W-1:0]   ux_s1, uy_s1, uz_s1;
	logic [IW-1:0]             it_s1;
	logic signed [RED_W-1:0]   ax_s2, ay_s2, az_s2;
	logic [CSTW-1:0]           cst_s2;
	logic signed [RED_W:0]     sxy_s3, szc_s3;
	logic signed [RED_W+1:0]   d_s4;
	logic signed [CLAMP_W-1:0] dc_s5;
	logic signed [PH_W-1:0]    ph_s6;
	logic [PL_W-1:0]           pl_s6;
	logic signed [RES_W-1:0]   r_s7;

	logic signed [HI_W-1:0]    dh;
	logic [SPLIT_W-1:0]        dl;
	logic signed [PH_W-1:0]    ph;
	logic [PL_W-1:0]           pl;
	logic signed [PROD_W-1:0]  prod;
	logic signed [RED_W+1:0]   dclamp;

	// split constant multiply and final product
	always_comb begin
		dh = $signed(dc_s5[CLAMP_W-1:SPLIT_W]);
		dl = dc_s5[SPLIT_W-1:0];
		ph = PH_W'(dh) * PH_W'($signed({1'b0, INV_SQRT3_Q24}));
		pl = PL_W'(dl) * PL_W'(INV_SQRT3_Q24);
		prod = $signed({ph_s6[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
			+ $signed({{(PROD_W-PL_W){1'b0}}, pl_s6});
		if (d_s4 > LIM) begin
			dclamp = LIM;
		end else if (d_s4 < -LIM) begin
			dclamp = -LIM;
		end else begin
			dclamp = d_s4;
		end
	end

	// tail valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= fold_v_s[NS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// reduce, absolute value, octahedron sum, clamp, multiply, scale
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1  <= reduce_f(fold_x_s[NS], fold_it_s[NS]);
			uy_s1  <= reduce_f(fold_y_s[NS], fold_it_s[NS]);
			uz_s1  <= reduce_f(fold_z_s[NS], fold_it_s[NS]);
			it_s1  <= fold_it_s[NS];
			ax_s2  <= ux_s1[RED_W-1] ? -ux_s1 : ux_s1;
			ay_s2  <= uy_s1[RED_W-1] ? -uy_s1 : uy_s1;
			az_s2  <= uz_s1[RED_W-1] ? -uz_s1 : uz_s1;
			cst_s2 <= ONE_G >> it_s1;
			sxy_s3 <= {ax_s2[RED_W-1], ax_s2} + {ay_s2[RED_W-1], ay_s2};
			szc_s3 <= {az_s2[RED_W-1], az_s2}
				- $signed({{(RED_W+1-CSTW){1'b0}}, cst_s2});
			d_s4   <= {sxy_s3[RED_W], sxy_s3} + {szc_s3[RED_W], szc_s3};
			dc_s5  <= dclamp[CLAMP_W-1:0];
			ph_s6  <= ph;
			pl_s6  <= pl;
			r_s7   <= prod[PROD_W-1:CONST_BITS+GUARD_BITS];
		end
	end

	// saturation to the output format
	logic                     ovf;
	logic signed [DIST_W-1:0] res_dist;

	always_comb begin
		ovf = !((r_s7[RES_W-1:DIST_W-1] == '0) || (r_s7[RES_W-1:DIST_W-1] == '1));
		if (ovf) begin
			res_dist = r_s7[RES_W-1] ? DIST_MIN : DIST_MAX;
		end else begin
			res_dist = r_s7[DIST_W-1:0];
		end
	end

	// two-entry output buffer
	logic                     out_valid_q;
	logic signed [DIST_W-1:0] distance_q;
	logic                     saturated_q;
	logic                     spare_valid_q;
	logic signed [DIST_W-1:0] spare_dist_q;
	logic                     spare_sat_q;
	logic                     push;
	logic                     pop;

	assign en          = !spare_valid_q;
	assign point_stall = spare_valid_q;
	assign push        = en && v_s7;
	assign pop         = out_valid_q && !dist_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (pop) begin
				spare_valid_q <= 1'b0;
			end
		end else if (push) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && !pop) begin
				spare_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (pop) begin
				distance_q  <= spare_dist_q;
				saturated_q <= spare_sat_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				distance_q  <= res_dist;
				saturated_q <= ovf;
			end else begin
				spare_dist_q <= res_dist;
				spare_sat_q  <= ovf;
			end
		end
	end

	assign dist_valid = out_valid_q;
	assign distance   = distance_q;
	assign saturated  = saturated_q;

	// the spare entry only holds a transaction behind a waiting one
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> dist_valid)
		else $error("spare entry valid while output register empty");

	// the spare entry fills only when the sink stalled a waiting transaction
	a_spare_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spare_valid_q) |-> $past(dist_valid && dist_stall))
		else $error("spare entry filled without an output stall");

	// a clipped distance sits at one end of the range
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(dist_valid && saturated) |-> (distance == DIST_MAX || distance == DIST_MIN))
		else $error("saturated flag with distance inside the range");

endmodule

`default_nettype wire
